@@ src/gobc_pkg.sv @@
// Shared types and constants for the grid offset bilinear correction block.
package gobc_pkg;

	localparam int DROP_BITS = 4;
	localparam int SW = 16 - DROP_BITS;
	localparam int AREA_W = 2 * SW;
	localparam logic [15:0] MIN_PITCH = 16'd16;

	typedef enum logic {
		ACT_WRITE   = 1'b0,
		ACT_CORRECT = 1'b1
	} action_t;

	typedef enum logic [2:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_PITCH_X  = 3'd2,
		REG_PITCH_Y  = 3'd3,
		REG_SPAN_X   = 3'd4,
		REG_SPAN_Y   = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		action_t            action;
		logic [15:0]        coord_x;
		logic [15:0]        coord_y;
		logic [3:0]         grid_col;
		logic [3:0]         grid_row;
		logic signed [15:0] entry_dx;
		logic signed [15:0] entry_dy;
	} item_t;

	typedef struct packed {
		logic [15:0] corrected_x;
		logic [15:0] corrected_y;
	} result_t;

endpackage

@@ src/gobc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module gobc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ src/grid_offset_bilinear_correction_top.sv @@
// Grid offset bilinear correction: fully pipelined, one beat per cycle.
//
// Each beat either stores one grid entry or corrects one X/Y coordinate by
// bilinear interpolation of the four surrounding grid offsets. The pipeline
// accepts a beat every cycle while the output is not stalled; write beats
// travel the same pipeline and give no result, so grid writes and
// corrections always take effect in beat order. Most of the pipeline is
// two bit-serial restoring dividers laid out as stages (16 for the cell
// index, 32 for the division by the cell area). The grid lives in four RAM
// banks split by row and column parity, so all four corners are read in
// the same cycle. A stall at the output holds the whole pipeline.
// Configuration registers may only be written while the pipeline is empty.
module grid_offset_bilinear_correction_top import gobc_pkg::*; #(
	parameter int GRID_POINTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_ready,
	output result_t     result,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	localparam int IW = $clog2(GRID_POINTS);
	localparam int HW = (IW > 1) ? IW - 1 : 1;
	localparam int BDEPTH = 1 << (2 * HW);
	localparam int QN = 16;
	localparam int EN = 32;

	function automatic logic [16:0] udiv16(input logic [15:0] rem, input logic nb,
		input logic [15:0] dvs);
		logic [16:0] t;
		t = {rem, nb};
		if (t >= {1'b0, dvs}) begin
			return {1'b1, 16'(t - {1'b0, dvs})};
		end
		return {1'b0, t[15:0]};
	endfunction

	function automatic logic [AREA_W:0] udiv_area(input logic [AREA_W-1:0] rem,
		input logic nb, input logic [AREA_W-1:0] dvs);
		logic [AREA_W:0] t;
		t = {rem, nb};
		if (t >= {1'b0, dvs}) begin
			return {1'b1, AREA_W'(t - {1'b0, dvs})};
		end
		return {1'b0, t[AREA_W-1:0]};
	endfunction

	function automatic logic [IW-1:0] cell_idx(input logic [15:0] q, input logic [31:0] prod,
		input logic [15:0] span);
		logic [15:0] i;
		i = q;
		if (prod >= {16'b0, span} && q != 16'd0) begin
			i = q - 16'd1;
		end
		if (i > 16'(GRID_POINTS - 2)) begin
			i = 16'(GRID_POINTS - 2);
		end
		return IW'(i);
	endfunction

	// configuration
	logic [15:0] origin_x_q, origin_y_q, pitch_x_q, pitch_y_q, span_x_q, span_y_q;
	logic [AREA_W-1:0] area_q;
	logic [15:0] px, py;
	logic [SW-1:0] sx, sy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= 16'd0;
			origin_y_q <= 16'd0;
			pitch_x_q  <= 16'd4096;
			pitch_y_q  <= 16'd4096;
			span_x_q   <= 16'd61440;
			span_y_q   <= 16'd61440;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ORIGIN_X: origin_x_q <= cfg_wdata;
				REG_ORIGIN_Y: origin_y_q <= cfg_wdata;
				REG_PITCH_X:  pitch_x_q  <= cfg_wdata;
				REG_PITCH_Y:  pitch_y_q  <= cfg_wdata;
				REG_SPAN_X:   span_x_q   <= cfg_wdata;
				REG_SPAN_Y:   span_y_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign px = (pitch_x_q < MIN_PITCH) ? MIN_PITCH : pitch_x_q;
	assign py = (pitch_y_q < MIN_PITCH) ? MIN_PITCH : pitch_y_q;
	assign sx = px[15:DROP_BITS];
	assign sy = py[15:DROP_BITS];

	always_ff @(posedge clk) begin
		area_q <= AREA_W'(sx * sy);
	end

	// global advance: the whole pipeline moves unless the output is blocked
	logic en;
	logic v_s10;
	assign en = !v_s10 || result_ready;
	assign item_ready = en;

	// stage 1: offset from origin
	logic v_s1;
	item_t it_s1;
	logic [15:0] d_x_s1, d_y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1  <= item;
			d_x_s1 <= item.coord_x - origin_x_q;
			d_y_s1 <= item.coord_y - origin_y_q;
		end
	end

	// cell divider: one quotient bit per stage
	logic        v_sd [QN];
	item_t       it_sd [QN];
	logic [15:0] d_x_sd [QN], d_y_sd [QN];
	logic [15:0] rem_x_sd [QN], rem_y_sd [QN];
	logic [15:0] q_x_sd [QN], q_y_sd [QN];

	for (genvar k = 0; k < QN; k++) begin : g_cdiv
		logic        v_in;
		item_t       it_in;
		logic [15:0] dxi, dyi, rxi, ryi, qxi, qyi;
		logic [16:0] stx, sty;

		if (k == 0) begin : g_first
			assign v_in  = v_s1;
			assign it_in = it_s1;
			assign dxi   = d_x_s1;
			assign dyi   = d_y_s1;
			assign rxi   = '0;
			assign ryi   = '0;
			assign qxi   = '0;
			assign qyi   = '0;
		end else begin : g_next
			assign v_in  = v_sd[k-1];
			assign it_in = it_sd[k-1];
			assign dxi   = d_x_sd[k-1];
			assign dyi   = d_y_sd[k-1];
			assign rxi   = rem_x_sd[k-1];
			assign ryi   = rem_y_sd[k-1];
			assign qxi   = q_x_sd[k-1];
			assign qyi   = q_y_sd[k-1];
		end

		assign stx = udiv16(rxi, dxi[QN-1-k], px);
		assign sty = udiv16(ryi, dyi[QN-1-k], py);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[k] <= 1'b0;
			end else if (en) begin
				v_sd[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				it_sd[k]    <= it_in;
				d_x_sd[k]   <= dxi;
				d_y_sd[k]   <= dyi;
				rem_x_sd[k] <= stx[15:0];
				rem_y_sd[k] <= sty[15:0];
				q_x_sd[k]   <= {qxi[14:0], stx[16]};
				q_y_sd[k]   <= {qyi[14:0], sty[16]};
			end
		end
	end

	// stage 2: quotient times pitch for the far-edge test
	logic v_s2;
	item_t it_s2;
	logic [15:0] d_x_s2, d_y_s2, q_x_s2, q_y_s2;
	logic [31:0] prod_x_s2, prod_y_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_sd[QN-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s2     <= it_sd[QN-1];
			d_x_s2    <= d_x_sd[QN-1];
			d_y_s2    <= d_y_sd[QN-1];
			q_x_s2    <= q_x_sd[QN-1];
			q_y_s2    <= q_y_sd[QN-1];
			prod_x_s2 <= q_x_sd[QN-1] * px;
			prod_y_s2 <= q_y_sd[QN-1] * py;
		end
	end

	// stage 3: step back from the far edge, clamp into the grid
	logic v_s3;
	item_t it_s3;
	logic [15:0] d_x_s3, d_y_s3;
	logic [IW-1:0] ix_s3, iy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s3  <= it_s2;
			d_x_s3 <= d_x_s2;
			d_y_s3 <= d_y_s2;
			ix_s3  <= cell_idx(q_x_s2, prod_x_s2, span_x_q);
			iy_s3  <= cell_idx(q_y_s2, prod_y_s2, span_y_q);
		end
	end

	// grid banks by {row parity, column parity}; writes go in at this stage
	logic          wr_ok;
	logic [IW-1:0] wcol, wrow;
	logic [31:0]   rd_s4 [4];

	assign wcol  = IW'(it_s3.grid_col);
	assign wrow  = IW'(it_s3.grid_row);
	assign wr_ok = en && v_s3 && it_s3.action == ACT_WRITE
		&& {28'b0, it_s3.grid_col} < 32'(GRID_POINTS)
		&& {28'b0, it_s3.grid_row} < 32'(GRID_POINTS);

	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam bit BC = bit'(b % 2);
		localparam bit BR = bit'(b / 2);
		logic [IW-1:0] rcol, rrow;

		assign rcol = (ix_s3[0] == BC) ? ix_s3 : IW'(ix_s3 + IW'(1));
		assign rrow = (iy_s3[0] == BR) ? iy_s3 : IW'(iy_s3 + IW'(1));

		gobc_ram #(
			.WIDTH(32),
			.DEPTH(BDEPTH)
		) u_bank (
			.clk  (clk),
			.we   (wr_ok && wcol[0] == BC && wrow[0] == BR),
			.waddr({HW'(wrow >> 1), HW'(wcol >> 1)}),
			.wdata({it_s3.entry_dx, it_s3.entry_dy}),
			.re   (en),
			.raddr({HW'(rrow >> 1), HW'(rcol >> 1)}),
			.rdata(rd_s4[b])
		);
	end

	// stage 4: grid data arrives
	logic v_s4;
	item_t it_s4;
	logic [15:0] d_x_s4, d_y_s4;
	logic [IW-1:0] ix_s4, iy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s4  <= it_s3;
			d_x_s4 <= d_x_s3;
			d_y_s4 <= d_y_s3;
			ix_s4  <= ix_s3;
			iy_s4  <= iy_s3;
		end
	end

	// stage 5: distances to the cell edges, corner pick
	logic [31:0] x0, y0, xp, yp;
	logic v_s5;
	item_t it_s5;
	logic [31:0] a_x_s5, b_x_s5, a_y_s5, b_y_s5;
	logic [31:0] c_s5 [4];

	assign x0 = 32'(ix_s4) * 32'(sx);
	assign y0 = 32'(iy_s4) * 32'(sy);
	assign xp = 32'(d_x_s4[15:DROP_BITS]);
	assign yp = 32'(d_y_s4[15:DROP_BITS]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s5  <= it_s4;
			a_x_s5 <= x0 + 32'(sx) - xp;
			b_x_s5 <= xp - x0;
			a_y_s5 <= y0 + 32'(sy) - yp;
			b_y_s5 <= yp - y0;
			c_s5[0] <= rd_s4[{iy_s4[0], ix_s4[0]}];
			c_s5[1] <= rd_s4[{iy_s4[0], !ix_s4[0]}];
			c_s5[2] <= rd_s4[{!iy_s4[0], ix_s4[0]}];
			c_s5[3] <= rd_s4[{!iy_s4[0], !ix_s4[0]}];
		end
	end

	// stage 6: corner weights
	logic v_s6;
	item_t it_s6;
	logic [31:0] w_s6 [4];
	logic [31:0] c_s6 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s6   <= it_s5;
			w_s6[0] <= a_x_s5 * a_y_s5;
			w_s6[1] <= b_x_s5 * a_y_s5;
			w_s6[2] <= a_x_s5 * b_y_s5;
			w_s6[3] <= b_x_s5 * b_y_s5;
			c_s6    <= c_s5;
		end
	end

	// stage 7: weighted corners
	logic v_s7;
	item_t it_s7;
	logic [31:0] m_x_s7 [4], m_y_s7 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s7 <= it_s6;
			for (int j = 0; j < 4; j++) begin
				m_x_s7[j] <= {{16{c_s6[j][31]}}, c_s6[j][31:16]} * w_s6[j];
				m_y_s7[j] <= {{16{c_s6[j][15]}}, c_s6[j][15:0]} * w_s6[j];
			end
		end
	end

	// stage 8: sums
	logic v_s8;
	item_t it_s8;
	logic [31:0] sum_x_s8, sum_y_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s8    <= it_s7;
			sum_x_s8 <= m_x_s7[0] + m_x_s7[1] + m_x_s7[2] + m_x_s7[3];
			sum_y_s8 <= m_y_s7[0] + m_y_s7[1] + m_y_s7[2] + m_y_s7[3];
		end
	end

	// stage 9: sign and magnitude for a truncating divide
	logic v_s9;
	item_t it_s9;
	logic neg_x_s9, neg_y_s9;
	logic [31:0] mag_x_s9, mag_y_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s9    <= it_s8;
			neg_x_s9 <= sum_x_s8[31];
			neg_y_s9 <= sum_y_s8[31];
			mag_x_s9 <= sum_x_s8[31] ? 32'(-sum_x_s8) : sum_x_s8;
			mag_y_s9 <= sum_y_s8[31] ? 32'(-sum_y_s8) : sum_y_s8;
		end
	end

	// area divider: one quotient bit per stage, keep the low 16 bits
	logic              v_se [EN];
	item_t             it_se [EN];
	logic              neg_x_se [EN], neg_y_se [EN];
	logic [31:0]       mag_x_se [EN], mag_y_se [EN];
	logic [AREA_W-1:0] rem_x_se [EN], rem_y_se [EN];
	logic [15:0]       q_x_se [EN], q_y_se [EN];

	for (genvar k = 0; k < EN; k++) begin : g_adiv
		logic              v_in, nxi, nyi;
		item_t             it_in;
		logic [31:0]       mxi, myi;
		logic [AREA_W-1:0] rxi, ryi;
		logic [15:0]       qxi, qyi;
		logic [AREA_W:0]   stx, sty;

		if (k == 0) begin : g_first
			assign v_in  = v_s9;
			assign it_in = it_s9;
			assign nxi   = neg_x_s9;
			assign nyi   = neg_y_s9;
			assign mxi   = mag_x_s9;
			assign myi   = mag_y_s9;
			assign rxi   = '0;
			assign ryi   = '0;
			assign qxi   = '0;
			assign qyi   = '0;
		end else begin : g_next
			assign v_in  = v_se[k-1];
			assign it_in = it_se[k-1];
			assign nxi   = neg_x_se[k-1];
			assign nyi   = neg_y_se[k-1];
			assign mxi   = mag_x_se[k-1];
			assign myi   = mag_y_se[k-1];
			assign rxi   = rem_x_se[k-1];
			assign ryi   = rem_y_se[k-1];
			assign qxi   = q_x_se[k-1];
			assign qyi   = q_y_se[k-1];
		end

		assign stx = udiv_area(rxi, mxi[EN-1-k], area_q);
		assign sty = udiv_area(ryi, myi[EN-1-k], area_q);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_se[k] <= 1'b0;
			end else if (en) begin
				v_se[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				it_se[k]    <= it_in;
				neg_x_se[k] <= nxi;
				neg_y_se[k] <= nyi;
				mag_x_se[k] <= mxi;
				mag_y_se[k] <= myi;
				rem_x_se[k] <= stx[AREA_W-1:0];
				rem_y_se[k] <= sty[AREA_W-1:0];
				q_x_se[k]   <= {qxi[14:0], stx[AREA_W]};
				q_y_se[k]   <= {qyi[14:0], sty[AREA_W]};
			end
		end
	end

	// stage 10: apply the offset; write beats drop out here
	result_t res_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s10 <= v_se[EN-1] && it_se[EN-1].action == ACT_CORRECT;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s10.corrected_x <= neg_x_se[EN-1] ? it_se[EN-1].coord_x - q_x_se[EN-1]
				: it_se[EN-1].coord_x + q_x_se[EN-1];
			res_s10.corrected_y <= neg_y_se[EN-1] ? it_se[EN-1].coord_y - q_y_se[EN-1]
				: it_se[EN-1].coord_y + q_y_se[EN-1];
		end
	end

	assign result_valid = v_s10;
	assign result       = res_s10;

endmodule
